@@ rtl/prq_pkg.sv @@
package prq_pkg;

  // Port widths of the command and result channels
  localparam int OP_W         = 3;
  localparam int SLOT_PORT_W  = 5;
  localparam int PRIO_PORT_W  = 6;
  localparam int STATUS_W     = 2;
  localparam int COUNT_PORT_W = 6;

  // Default sizing
  localparam int MAX_THREADS_DEF     = 32;
  localparam int PRIORITY_LEVELS_DEF = 64;

  // Command codes
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_SLEEP   = 3'd1;
  localparam logic [OP_W-1:0] OP_WAKE    = 3'd2;
  localparam logic [OP_W-1:0] OP_KILL    = 3'd3;
  localparam logic [OP_W-1:0] OP_RESCHED = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  // Thread slot states
  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_SLEEP   = 2'd3
  } slot_state_t;

  // Operation applied to every cell of the ready queue in the same cycle
  typedef enum logic [1:0] {
    Q_HOLD       = 2'd0,
    Q_INSERT     = 2'd1,
    Q_POP_HEAD   = 2'd2,
    Q_REMOVE_ALL = 2'd3
  } qop_t;

  // Chain signals handed from one cell to its right neighbor
  typedef struct packed {
    logic le;    // left cell holds an entry that stays ahead of the new one
    logic hole;  // the slot to remove sits at or left of this point
  } link_t;

endpackage

@@ rtl/prq_cell.sv @@
module prq_cell #(
  parameter int SLOT_W = 5,
  parameter int PRIO_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prq_pkg::qop_t       op,
  input  logic [SLOT_W-1:0]   new_slot,
  input  logic [PRIO_W-1:0]   new_prio,
  input  logic                left_valid,
  input  logic [SLOT_W-1:0]   left_slot,
  input  logic [PRIO_W-1:0]   left_prio,
  input  logic                right_valid,
  input  logic [SLOT_W-1:0]   right_slot,
  input  logic [PRIO_W-1:0]   right_prio,
  input  prq_pkg::link_t      link_in,
  output prq_pkg::link_t      link_out,
  output logic                valid_r,
  output logic [SLOT_W-1:0]   slot_r,
  output logic [PRIO_W-1:0]   prio_r
);
  import prq_pkg::*;

  logic              valid_nxt;
  logic [SLOT_W-1:0] slot_nxt;
  logic [PRIO_W-1:0] prio_nxt;
  logic              stays;
  logic              hit;

  assign stays         = valid_r && (prio_r <= new_prio);
  assign hit           = valid_r && (slot_r == new_slot);
  assign link_out.le   = stays;
  assign link_out.hole = link_in.hole | hit;

  always_comb begin
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    prio_nxt  = prio_r;
    unique case (op)
      Q_INSERT: begin
        if (stays) begin
          // keep: entry ranks ahead of the new one
        end else if (link_in.le) begin
          valid_nxt = 1'b1;
          slot_nxt  = new_slot;
          prio_nxt  = new_prio;
        end else begin
          valid_nxt = left_valid;
          slot_nxt  = left_slot;
          prio_nxt  = left_prio;
        end
      end
      Q_POP_HEAD: begin
        valid_nxt = right_valid;
        slot_nxt  = right_slot;
        prio_nxt  = right_prio;
      end
      Q_REMOVE_ALL: begin
        if (link_in.hole || hit) begin
          valid_nxt = right_valid;
          slot_nxt  = right_slot;
          prio_nxt  = right_prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    prio_r <= prio_nxt;
  end

endmodule

@@ rtl/prq_queue.sv @@
module prq_queue #(
  parameter int DEPTH  = 32,
  parameter int SLOT_W = 5,
  parameter int PRIO_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prq_pkg::qop_t     op,
  input  logic [SLOT_W-1:0] new_slot,
  input  logic [PRIO_W-1:0] new_prio,
  output logic              head_valid,
  output logic [SLOT_W-1:0] head_slot,
  output logic [PRIO_W-1:0] head_prio
);
  import prq_pkg::*;

  logic              valid_q [DEPTH];
  logic [SLOT_W-1:0] slot_q  [DEPTH];
  logic [PRIO_W-1:0] prio_q  [DEPTH];
  link_t             link_q  [DEPTH+1];

  // Head of the chain: new entry goes first unless a cell claims the spot
  assign link_q[0] = '{le: 1'b1, hole: 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              lv;
    logic [SLOT_W-1:0] ls;
    logic [PRIO_W-1:0] lp;
    logic              rv;
    logic [SLOT_W-1:0] rs;
    logic [PRIO_W-1:0] rp;

    if (i == 0) begin : g_first
      assign lv = 1'b0;
      assign ls = '0;
      assign lp = '0;
    end else begin : g_mid
      assign lv = valid_q[i-1];
      assign ls = slot_q[i-1];
      assign lp = prio_q[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign rv = 1'b0;
      assign rs = '0;
      assign rp = '0;
    end else begin : g_inner
      assign rv = valid_q[i+1];
      assign rs = slot_q[i+1];
      assign rp = prio_q[i+1];
    end

    prq_cell #(
      .SLOT_W (SLOT_W),
      .PRIO_W (PRIO_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .new_slot    (new_slot),
      .new_prio    (new_prio),
      .left_valid  (lv),
      .left_slot   (ls),
      .left_prio   (lp),
      .right_valid (rv),
      .right_slot  (rs),
      .right_prio  (rp),
      .link_in     (link_q[i]),
      .link_out    (link_q[i+1]),
      .valid_r     (valid_q[i]),
      .slot_r      (slot_q[i]),
      .prio_r      (prio_q[i])
    );
  end

  assign head_valid = valid_q[0];
  assign head_slot  = slot_q[0];
  assign head_prio  = prio_q[0];

endmodule

@@ rtl/priority_ready_queue_scheduler.sv @@
// Hardware thread scheduler with a priority-ordered ready queue.
//
// Command channel: drive in_op, in_thread_slot and in_priority_req with
// start high; the transaction is taken at the clock edge where start is high
// and busy is low. Ops: create (lowest free slot, queued, no reschedule),
// sleep the running thread, wake a slot, kill a slot, reschedule.
// Result channel: one transaction per command. out_valid is high for exactly
// one cycle and carries the running slot, a switch flag, the created slot,
// a status code and the ready queue length. The receiver cannot stall; it
// must take the result in that cycle.
//
// Timing: the ready queue is a row of cells, one entry each, that shift in
// step. After the accept edge the sequencer passes through DECODE, then
// straight to FINISH for create and invalid requests, through RESCHED for
// sleep, wake, kill or reschedule, and through RESCHED and PREEMPT when the
// running thread is preempted (pop head, then reinsert the old thread). The
// result strobe is raised in FINISH, and busy drops the cycle after the strobe.
//
// Reset (synchronous, rst_n low): all slots free, queue empty, nothing runs.
// No clearing pass is needed.
module priority_ready_queue_scheduler #(
  parameter int MAX_THREADS     = prq_pkg::MAX_THREADS_DEF,
  parameter int PRIORITY_LEVELS = prq_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [prq_pkg::OP_W-1:0]            in_op,
  input  logic [prq_pkg::SLOT_PORT_W-1:0]     in_thread_slot,
  input  logic [prq_pkg::PRIO_PORT_W-1:0]     in_priority_req,
  output logic                                out_valid,
  output logic [prq_pkg::SLOT_PORT_W-1:0]     out_running_slot,
  output logic                                out_running_valid,
  output logic                                out_switched,
  output logic [prq_pkg::SLOT_PORT_W-1:0]     out_created_slot,
  output logic [prq_pkg::STATUS_W-1:0]        out_status,
  output logic [prq_pkg::COUNT_PORT_W-1:0]    out_ready_count
);
  import prq_pkg::*;

  localparam int SLOT_W = $clog2(MAX_THREADS);
  localparam int PRIO_W = $clog2(PRIORITY_LEVELS);
  localparam int LEN_W  = $clog2(MAX_THREADS + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_RESCHED = 3'd2;
  localparam logic [2:0] S_PREEMPT = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0]             state_r, state_nxt;

  // Latched command transaction
  logic [OP_W-1:0]        op_r;
  logic [SLOT_PORT_W-1:0] req_slot_in_r;
  logic [PRIO_PORT_W-1:0] req_prio_in_r;
  logic                   was_valid_r;
  logic [SLOT_W-1:0]      was_slot_r;

  // Result fields
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [SLOT_W-1:0]      created_r, created_nxt;

  // Running thread
  logic                   cur_valid_r, cur_valid_nxt;
  logic [SLOT_W-1:0]      cur_slot_r, cur_slot_nxt;
  logic [PRIO_W-1:0]      cur_prio_r, cur_prio_nxt;

  // Preempted thread waiting to go back into the queue
  logic [SLOT_W-1:0]      pend_slot_r, pend_slot_nxt;
  logic [PRIO_W-1:0]      pend_prio_r, pend_prio_nxt;

  logic [LEN_W-1:0]       len_r, len_nxt;

  // Per-slot state and priority
  slot_state_t            slot_state_r [MAX_THREADS];
  logic [PRIO_W-1:0]      slot_prio_r  [MAX_THREADS];
  logic                   st_we;
  logic [SLOT_W-1:0]      st_wslot;
  slot_state_t            st_wval;
  logic                   pr_we;

  // Lowest free slot, registered from the slot state
  logic                   ffs_any, ffs_any_r;
  logic [SLOT_W-1:0]      ffs_slot, ffs_slot_r;

  // Queue control
  qop_t                   q_op;
  logic [SLOT_W-1:0]      q_slot;
  logic [PRIO_W-1:0]      q_prio;
  logic                   head_valid;
  logic [SLOT_W-1:0]      head_slot;
  logic [PRIO_W-1:0]      head_prio;

  logic [SLOT_W-1:0]      req_slot;
  logic                   req_oob;
  slot_state_t            req_state;
  logic [PRIO_W-1:0]      create_prio;
  logic                   accept;

  assign accept    = start && (state_r == S_IDLE);
  assign req_slot  = SLOT_W'(req_slot_in_r);
  assign req_oob   = int'(req_slot_in_r) >= MAX_THREADS;
  assign req_state = slot_state_r[req_slot];

  // Saturate out-of-range priorities to the least urgent level
  assign create_prio = (int'(req_prio_in_r) >= PRIORITY_LEVELS) ?
                       PRIO_W'(PRIORITY_LEVELS - 1) : PRIO_W'(req_prio_in_r);

  prq_queue #(
    .DEPTH  (MAX_THREADS),
    .SLOT_W (SLOT_W),
    .PRIO_W (PRIO_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (q_op),
    .new_slot   (q_slot),
    .new_prio   (q_prio),
    .head_valid (head_valid),
    .head_slot  (head_slot),
    .head_prio  (head_prio)
  );

  // Find the lowest free slot; the result is registered before use
  always_comb begin
    ffs_any  = 1'b0;
    ffs_slot = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (slot_state_r[i] == ST_FREE) begin
        ffs_any  = 1'b1;
        ffs_slot = SLOT_W'(i);
      end
    end
  end

  // Sequencer: at most one queue operation and one slot state write per cycle
  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    created_nxt   = created_r;
    cur_valid_nxt = cur_valid_r;
    cur_slot_nxt  = cur_slot_r;
    cur_prio_nxt  = cur_prio_r;
    pend_slot_nxt = pend_slot_r;
    pend_prio_nxt = pend_prio_r;
    len_nxt       = len_r;
    st_we         = 1'b0;
    st_wslot      = req_slot;
    st_wval       = ST_FREE;
    pr_we         = 1'b0;
    q_op          = Q_HOLD;
    q_slot        = req_slot;
    q_prio        = create_prio;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt  = STATUS_OK;
          created_nxt = '0;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (op_r)
          OP_CREATE: begin
            state_nxt = S_FINISH;
            if (!ffs_any_r) begin
              status_nxt = STATUS_NO_SLOT;
            end else begin
              // Queue the new thread without rescheduling
              pr_we       = 1'b1;
              st_we       = 1'b1;
              st_wslot    = ffs_slot_r;
              st_wval     = ST_READY;
              q_op        = Q_INSERT;
              q_slot      = ffs_slot_r;
              q_prio      = create_prio;
              len_nxt     = len_r + LEN_W'(1);
              created_nxt = ffs_slot_r;
            end
          end
          OP_SLEEP: begin
            if (!cur_valid_r) begin
              status_nxt = STATUS_INVALID;
              state_nxt  = S_FINISH;
            end else begin
              st_we         = 1'b1;
              st_wslot      = cur_slot_r;
              st_wval       = ST_SLEEP;
              cur_valid_nxt = 1'b0;
              state_nxt     = S_RESCHED;
            end
          end
          OP_WAKE: begin
            if (req_oob || (req_state != ST_SLEEP)) begin
              status_nxt = STATUS_INVALID;
              state_nxt  = S_FINISH;
            end else begin
              st_we     = 1'b1;
              st_wval   = ST_READY;
              q_op      = Q_INSERT;
              q_prio    = slot_prio_r[req_slot];
              len_nxt   = len_r + LEN_W'(1);
              state_nxt = S_RESCHED;
            end
          end
          OP_KILL: begin
            if (req_oob || (req_state == ST_FREE)) begin
              status_nxt = STATUS_INVALID;
              state_nxt  = S_FINISH;
            end else begin
              if (req_state == ST_READY) begin
                q_op    = Q_REMOVE_ALL;
                len_nxt = len_r - LEN_W'(1);
              end
              if (cur_valid_r && (cur_slot_r == req_slot)) begin
                cur_valid_nxt = 1'b0;
              end
              st_we     = 1'b1;
              st_wval   = ST_FREE;
              state_nxt = S_RESCHED;
            end
          end
          OP_RESCHED: begin
            state_nxt = S_RESCHED;
          end
          default: begin
            status_nxt = STATUS_INVALID;
            state_nxt  = S_FINISH;
          end
        endcase
      end

      S_RESCHED: begin
        state_nxt = S_FINISH;
        if (cur_valid_r) begin
          // Preempt only on a strictly more urgent head
          if ((len_r != LEN_W'(0)) && (head_prio < cur_prio_r)) begin
            q_op          = Q_POP_HEAD;
            len_nxt       = len_r - LEN_W'(1);
            st_we         = 1'b1;
            st_wslot      = head_slot;
            st_wval       = ST_RUNNING;
            pend_slot_nxt = cur_slot_r;
            pend_prio_nxt = cur_prio_r;
            cur_slot_nxt  = head_slot;
            cur_prio_nxt  = head_prio;
            state_nxt     = S_PREEMPT;
          end
        end else if (len_r == LEN_W'(0)) begin
          // Halt
          cur_slot_nxt = '0;
        end else begin
          q_op          = Q_POP_HEAD;
          len_nxt       = len_r - LEN_W'(1);
          st_we         = 1'b1;
          st_wslot      = head_slot;
          st_wval       = ST_RUNNING;
          cur_valid_nxt = 1'b1;
          cur_slot_nxt  = head_slot;
          cur_prio_nxt  = head_prio;
        end
      end

      S_PREEMPT: begin
        // Put the preempted thread back behind its equals
        q_op      = Q_INSERT;
        q_slot    = pend_slot_r;
        q_prio    = pend_prio_r;
        len_nxt   = len_r + LEN_W'(1);
        st_we     = 1'b1;
        st_wslot  = pend_slot_r;
        st_wval   = ST_READY;
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_valid_r <= 1'b0;
      cur_slot_r  <= '0;
      len_r       <= '0;
      ffs_any_r   <= 1'b0;
      for (int i = 0; i < MAX_THREADS; i++) begin
        slot_state_r[i] <= ST_FREE;
      end
    end else begin
      state_r     <= state_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_slot_r  <= cur_slot_nxt;
      len_r       <= len_nxt;
      ffs_any_r   <= ffs_any;
      if (st_we) begin
        slot_state_r[st_wslot] <= st_wval;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r          <= in_op;
      req_slot_in_r <= in_thread_slot;
      req_prio_in_r <= in_priority_req;
      was_valid_r   <= cur_valid_r;
      was_slot_r    <= cur_slot_r;
    end
    status_r    <= status_nxt;
    created_r   <= created_nxt;
    cur_prio_r  <= cur_prio_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_prio_r <= pend_prio_nxt;
    ffs_slot_r  <= ffs_slot;
    if (pr_we) begin
      slot_prio_r[ffs_slot_r] <= create_prio;
    end
  end

  // Result transaction, driven from registers
  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_FINISH);
  assign out_running_valid = cur_valid_r;
  assign out_running_slot  = cur_valid_r ? SLOT_PORT_W'(cur_slot_r) : '0;
  assign out_switched      = (was_valid_r != cur_valid_r) ||
                             (cur_valid_r && (was_slot_r != cur_slot_r));
  assign out_created_slot  = SLOT_PORT_W'(created_r);
  assign out_status        = status_r;
  assign out_ready_count   = COUNT_PORT_W'(len_r);

`ifndef SYNTHESIS
  a_run_state: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (slot_state_r[cur_slot_r] == ST_RUNNING))
    else $error("running thread slot is not in running state");

  a_head_len: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid == (len_r != LEN_W'(0)))
    else $error("queue head disagrees with queue length");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted command did not enter the sequencer");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_halt_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !cur_valid_r) |-> (cur_slot_r == '0))
    else $error("halted result with nonzero running slot");
`endif

endmodule
